[rtl/pcmc_pkg.sv]
// ----------------------------------------------------------------------------
// pcmc_pkg
// Shared types and constants of the PCM sample converter.
// ----------------------------------------------------------------------------
package pcmc_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_IS_FLOAT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_BITS       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SURROUND_REORDER = 8'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0] sample_bytes;
        logic       sample_is_float;
        logic [5:0] valid_bits;
        logic       surround_reorder;
    } t_cfg;

    typedef struct packed {
        logic [2:0][15:0] vals;
        logic [1:0]       cnt;
        logic             fin;
    } t_cmd;

endpackage

[rtl/pcmc_front.sv]
// ----------------------------------------------------------------------------
// pcmc_front
// Converts each accepted sample and builds the result group of the reorder.
// ----------------------------------------------------------------------------
module pcmc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [pcmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_accept,
    input  logic [31:0]                  i_raw_sample,
    input  logic                         i_final_sample,
    output pcmc_pkg::t_cmd               o_cmd,
    output logic                         o_cmd_valid
);

    pcmc_pkg::t_cfg r_cfg;
    logic [2:0]     r_pos, n_pos;
    logic [15:0]    r_h0, r_h1, n_h0, n_h1;

    logic [7:0]  exp_f;
    logic [23:0] mant;
    logic [7:0]  sh;
    logic [30:0] big, q;
    logic [16:0] rnd;
    logic [15:0] f_res, i_res, win, mask, s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_bytes     <= 3'd2;
            r_cfg.sample_is_float  <= 1'b0;
            r_cfg.valid_bits       <= 6'd16;
            r_cfg.surround_reorder <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pcmc_pkg::CFG_SAMPLE_BYTES:     r_cfg.sample_bytes     <= i_cfg_data[2:0];
                pcmc_pkg::CFG_SAMPLE_IS_FLOAT:  r_cfg.sample_is_float  <= i_cfg_data[0];
                pcmc_pkg::CFG_VALID_BITS:       r_cfg.valid_bits       <= i_cfg_data[5:0];
                pcmc_pkg::CFG_SURROUND_REORDER: r_cfg.surround_reorder <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        exp_f = i_raw_sample[30:23];
        mant  = {(exp_f != 8'd0), i_raw_sample[22:0]};
        sh    = 8'd141 - exp_f;
        big   = {mant, 7'b0};
        q     = (sh > 8'd30) ? 31'd0 : (big >> sh[4:0]);
        rnd   = {1'b0, q[15:0]} + 17'd1;
        if (exp_f == 8'hFF && i_raw_sample[22:0] != 23'd0) begin
            f_res = 16'd0;
        end else if (exp_f >= 8'd127) begin
            f_res = i_raw_sample[31] ? 16'h8000 : 16'h7FFF;
        end else if (i_raw_sample[31]) begin
            f_res = 16'(~rnd[16:1] + 16'd1);
        end else begin
            f_res = (rnd[16:1] == 16'h8000) ? 16'h7FFF : rnd[16:1];
        end
    end

    always_comb begin
        case (r_cfg.sample_bytes)
            3'd2:    win = i_raw_sample[15:0];
            3'd3:    win = i_raw_sample[23:8];
            default: win = i_raw_sample[31:16];
        endcase
        if (r_cfg.valid_bits >= 6'd16) begin
            mask = 16'hFFFF;
        end else begin
            mask = 16'hFFFF << (5'd16 - 5'(r_cfg.valid_bits));
        end
        case (r_cfg.sample_bytes)
            3'd1:              i_res = {~i_raw_sample[7], i_raw_sample[6:0], 8'd0};
            3'd2, 3'd3, 3'd4:  i_res = win & mask;
            default:           i_res = 16'd0;
        endcase
        s = r_cfg.sample_is_float ? f_res : i_res;
    end

    always_comb begin
        n_pos       = 3'd0;
        n_h0        = r_h0;
        n_h1        = r_h1;
        o_cmd.vals  = {16'd0, 16'd0, s};
        o_cmd.cnt   = 2'd1;
        o_cmd.fin   = i_final_sample;
        if (r_cfg.surround_reorder) begin
            case (r_pos)
                3'd1: begin
                    n_h0 = s;
                    n_pos = 3'd2;
                    o_cmd.cnt = i_final_sample ? 2'd1 : 2'd0;
                end
                3'd2: begin
                    o_cmd.vals = {16'd0, r_h0, s};
                    o_cmd.cnt = 2'd2;
                    n_pos = 3'd3;
                end
                3'd3: begin
                    n_h0 = s;
                    n_pos = 3'd4;
                    o_cmd.cnt = i_final_sample ? 2'd1 : 2'd0;
                end
                3'd4: begin
                    n_h1 = s;
                    n_pos = 3'd5;
                    o_cmd.vals = {16'd0, s, r_h0};
                    o_cmd.cnt = i_final_sample ? 2'd2 : 2'd0;
                end
                3'd5: begin
                    o_cmd.vals = {r_h1, r_h0, s};
                    o_cmd.cnt = 2'd3;
                    n_pos = 3'd0;
                end
                default: begin
                    n_pos = 3'd1;
                end
            endcase
            if (i_final_sample) begin
                n_pos = 3'd0;
            end
        end
        o_cmd_valid = i_accept && (o_cmd.cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
        end
    end

endmodule

[rtl/pcmc_back.sv]
// ----------------------------------------------------------------------------
// pcmc_back
// Queues result groups and hands them out one result per transaction.
// ----------------------------------------------------------------------------
module pcmc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pcmc_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [15:0]    o_pcm_sample,
    output logic           o_run_last,
    output logic           o_block_end
);

    pcmc_pkg::t_cmd r_q [pcmc_pkg::QUEUE_DEPTH];
    logic [pcmc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [pcmc_pkg::QPTR_W:0]   r_count;
    logic [1:0]                  r_idx;
    pcmc_pkg::t_cmd              head;
    logic                        take, done;

    assign head         = r_q[r_rd];
    assign o_empty      = (r_count == '0);
    assign o_full       = (r_count == (pcmc_pkg::QPTR_W+1)'(pcmc_pkg::QUEUE_DEPTH));
    assign o_pcm_sample = head.vals[r_idx];
    assign o_run_last   = (r_idx == head.cnt - 2'd1);
    assign o_block_end  = o_run_last && head.fin;
    assign take         = i_pop && !o_empty;
    assign done         = take && o_run_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid) begin
            r_q[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_idx   <= 2'd0;
        end else begin
            if (i_cmd_valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (done) begin
                r_rd  <= r_rd + 1'b1;
                r_idx <= 2'd0;
            end else if (take) begin
                r_idx <= r_idx + 2'd1;
            end
            if (i_cmd_valid && !done) begin
                r_count <= r_count + 1'b1;
            end else if (done && !i_cmd_valid) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/pcm_sample_to_16bit_converter.sv]
// ----------------------------------------------------------------------------
// pcm_sample_to_16bit_converter
// Each accepted sample's results pass through the group queue to the output.
// Throughput: one sample per cycle in while the four-entry queue is not full;
// one result per cycle out while pop is held and empty is low, up to three
// results per group. Reset: synchronous active-low; clears the queue, frame
// position and the configuration to its defaults; o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module pcm_sample_to_16bit_converter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcmc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [31:0]                        i_raw_sample,
    input  logic                               i_final_sample,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [15:0]                 o_pcm_sample,
    output logic                               o_run_last,
    output logic                               o_block_end
);

    pcmc_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           accept;
    logic [15:0]    pcm;

    assign o_cfg_ready  = 1'b1;
    assign accept       = push && !full;
    assign o_pcm_sample = pcm;

    pcmc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_raw_sample   (i_raw_sample),
        .i_final_sample (i_final_sample),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid)
    );

    pcmc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cmd_valid  (cmd_valid),
        .o_full       (full),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pcm_sample (pcm),
        .o_run_last   (o_run_last),
        .o_block_end  (o_block_end)
    );

endmodule
